[rtl/lrukv_pkg.sv]
package lrukv_pkg;

  // Request codes carried on the opcode field.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Fixed field widths of the ports.
  localparam int OPCODE_BITS   = 2;
  localparam int KEY_PORT_BITS = 64;
  localparam int VALUE_BITS    = 32;
  localparam int CAP_BITS      = 5;

  // Register reset value and parameter defaults.
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 64;

endpackage

[rtl/lru_key_value_cache.sv]
// Fully associative key-value cache with least-recently-used replacement.
// Each transaction on the request side is an insert, a get or a query for the
// most recent key, and it produces exactly one result. The result reaches the
// result ports from the result register, marked by a one-cycle out_valid
// strobe. A new request can be accepted on every clock cycle while busy is
// low. The request is registered first. A single pass of logic then finishes
// it at the next edge, where the result is registered. That pass is a parallel
// key compare across all entries and a parallel update of the per-entry age
// counters. The receiver cannot hold results off, so it must take out_valid
// and the result fields in the cycle they appear.
// busy is high only during reset and until busy_r clears after it; there is
// no memory clearing pass. The capacity register may be written through the
// cfg_ channel whenever no request is in flight.
module lru_key_value_cache #(
  parameter int ENTRIES  = lrukv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lrukv_pkg::DEF_KEY_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  // Request channel.
  input  logic                                     start,
  output logic                                     busy,
  input  logic [lrukv_pkg::OPCODE_BITS-1:0]        in_opcode,
  input  logic [lrukv_pkg::KEY_PORT_BITS-1:0]      in_key,
  input  logic signed [lrukv_pkg::VALUE_BITS-1:0]  in_value_in,
  // Result channel.
  output logic                                     out_valid,
  output logic                                     out_hit,
  output logic signed [lrukv_pkg::VALUE_BITS-1:0]  out_value_out,
  output logic [lrukv_pkg::KEY_PORT_BITS-1:0]      out_key_out,
  // Capacity register write channel.
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [lrukv_pkg::CAP_BITS-1:0]           cfg_capacity
);

  localparam int AGE_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lrukv_pkg::CAP_BITS) ? CNT_W : lrukv_pkg::CAP_BITS;
  localparam int VW    = lrukv_pkg::VALUE_BITS;

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  logic                              busy_r;
  logic [lrukv_pkg::CAP_BITS-1:0]    cap_r;

  // Request register.
  logic                              req_vld_r;
  logic [lrukv_pkg::OPCODE_BITS-1:0] req_op_r;
  logic [KEY_BITS-1:0]               req_key_r;
  logic [VW-1:0]                     req_val_r;

  // Entry state. Keys and values hold garbage until written; every read of
  // them is qualified by the valid bit.
  logic [KEY_BITS-1:0] key_r   [ENTRIES];
  logic [VW-1:0]       val_r   [ENTRIES];
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [AGE_W-1:0]    age_r   [ENTRIES];
  logic [AGE_W-1:0]    age_nxt [ENTRIES];
  logic [CNT_W-1:0]    count_r, count_nxt;

  // Result register.
  logic                               out_vld_r;
  logic                               out_hit_r, out_hit_nxt;
  logic [VW-1:0]                      out_val_r, out_val_nxt;
  logic [lrukv_pkg::KEY_PORT_BITS-1:0] out_key_r, out_key_nxt;

  logic accept;

  // busy also covers the reset cycles themselves so that no transaction is
  // taken while the state is being cleared.
  assign busy      = busy_r | ~rst_n;
  assign accept    = start & ~busy;
  assign cfg_ready = ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      cap_r     <= lrukv_pkg::CAP_RESET;
      req_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      req_vld_r <= accept;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r  <= in_opcode;
      req_key_r <= in_key[KEY_BITS-1:0];
      req_val_r <= in_value_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup.
  // ---------------------------------------------------------------------------
  logic [ENTRIES-1:0] match_vec;
  logic               match_any;

  lrukv_match #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_match (
    .entry_keys  (key_r),
    .entry_valid (valid_r),
    .key         (req_key_r),
    .match_vec   (match_vec),
    .match_any   (match_any)
  );

  // Gather the age and value of the matching entry, the key of the most
  // recent entry, and the least recent entry (age equal to count minus one:
  // the ages of live entries always form a permutation of 0..count-1).
  logic [AGE_W-1:0]    hit_age;
  logic [VW-1:0]       hit_val;
  logic [KEY_BITS-1:0] mru_key;
  logic                mru_any;
  logic [ENTRIES-1:0]  victim_vec;
  logic [AGE_W-1:0]    oldest_age;
  logic [CMP_W-1:0]    eff_cap;
  logic                evict;
  logic [ENTRIES-1:0]  free_vec, slot_vec;

  assign oldest_age = AGE_W'(count_r - CNT_W'(1));

  always_comb begin
    hit_age = '0;
    hit_val = '0;
    mru_key = '0;
    mru_any = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_age = hit_age | age_r[i];
        hit_val = hit_val | val_r[i];
      end
      if (valid_r[i] && (age_r[i] == '0)) begin
        mru_key = mru_key | key_r[i];
        mru_any = 1'b1;
      end
      victim_vec[i] = valid_r[i] && (age_r[i] == oldest_age);
    end
  end

  // Effective capacity: zero acts as one, anything above the entry count
  // of the array acts as the full array.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_r);
    end
  end

  assign evict    = CMP_W'(count_r) >= eff_cap;
  // The new pair goes to the lowest free slot, counting the slot freed by
  // an eviction in the same transaction.
  assign free_vec = ~valid_r | (evict ? victim_vec : '0);
  assign slot_vec = free_vec & (~free_vec + ENTRIES'(1));

  // ---------------------------------------------------------------------------
  // State update and result.
  // ---------------------------------------------------------------------------
  logic [ENTRIES-1:0] key_we, val_we;

  always_comb begin
    valid_nxt   = valid_r;
    count_nxt   = count_r;
    key_we      = '0;
    val_we      = '0;
    out_hit_nxt = 1'b0;
    out_val_nxt = '0;
    out_key_nxt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      age_nxt[i] = age_r[i];
    end

    if (req_vld_r) begin
      case (req_op_r)
        lrukv_pkg::OP_INSERT: begin
          if (match_any) begin
            out_hit_nxt = 1'b1;
            val_we      = match_vec;
            for (int i = 0; i < ENTRIES; i++) begin
              if (match_vec[i]) begin
                age_nxt[i] = '0;
              end else if (valid_r[i] && (age_r[i] < hit_age)) begin
                age_nxt[i] = age_r[i] + AGE_W'(1);
              end
            end
          end else begin
            key_we = slot_vec;
            val_we = slot_vec;
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot_vec[i]) begin
                valid_nxt[i] = 1'b1;
                age_nxt[i]   = '0;
              end else if (evict && victim_vec[i]) begin
                valid_nxt[i] = 1'b0;
                age_nxt[i]   = '0;
              end else if (valid_r[i]) begin
                age_nxt[i] = age_r[i] + AGE_W'(1);
              end
            end
            count_nxt = evict ? count_r : count_r + CNT_W'(1);
          end
        end
        lrukv_pkg::OP_GET: begin
          if (match_any) begin
            out_hit_nxt = 1'b1;
            out_val_nxt = hit_val;
            for (int i = 0; i < ENTRIES; i++) begin
              if (match_vec[i]) begin
                age_nxt[i] = '0;
              end else if (valid_r[i] && (age_r[i] < hit_age)) begin
                age_nxt[i] = age_r[i] + AGE_W'(1);
              end
            end
          end
        end
        lrukv_pkg::OP_QUERY: begin
          out_hit_nxt = mru_any;
          out_key_nxt = lrukv_pkg::KEY_PORT_BITS'(mru_key);
        end
        default: begin
          // Unused opcode: state untouched, all-zero result.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r   <= valid_nxt;
      count_r   <= count_nxt;
      out_vld_r <= req_vld_r;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
    out_val_r <= out_val_nxt;
    out_key_r <= out_key_nxt;
    for (int i = 0; i < ENTRIES; i++) begin
      if (key_we[i]) begin
        key_r[i] <= req_key_r;
      end
      if (val_we[i]) begin
        val_r[i] <= req_val_r;
      end
    end
  end

  assign out_valid     = out_vld_r;
  assign out_hit       = out_hit_r;
  assign out_value_out = out_val_r;
  assign out_key_out   = out_key_r;

endmodule

[rtl/lrukv_match.sv]
module lrukv_match #(
  parameter int ENTRIES  = lrukv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lrukv_pkg::DEF_KEY_BITS
) (
  input  logic [KEY_BITS-1:0] entry_keys [ENTRIES],
  input  logic [ENTRIES-1:0]  entry_valid,
  input  logic [KEY_BITS-1:0] key,
  output logic [ENTRIES-1:0]  match_vec,
  output logic                match_any
);

  // Parallel compare of the request key against every live entry. Live keys
  // are unique, so at most one bit of match_vec is set.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (entry_keys[i] == key);
    end
  end

  assign match_any = |match_vec;

endmodule

[rtl/lrukv_checker.sv]
module lrukv_checker (
  input logic                                     clk,
  input logic                                     rst_n,
  input logic                                     start,
  input logic                                     busy,
  input logic [lrukv_pkg::OPCODE_BITS-1:0]        in_opcode,
  input logic [lrukv_pkg::KEY_PORT_BITS-1:0]      in_key,
  input logic signed [lrukv_pkg::VALUE_BITS-1:0]  in_value_in,
  input logic                                     out_valid,
  input logic                                     out_hit,
  input logic signed [lrukv_pkg::VALUE_BITS-1:0]  out_value_out,
  input logic [lrukv_pkg::KEY_PORT_BITS-1:0]      out_key_out
);

  logic acc;
  assign acc = start & ~busy;

  // Every accepted transaction gives its result once it has passed the request and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

  // No result appears without an earlier accepted transaction that it belongs to.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 2))
    else $error("result strobe without a request");

  // A result never carries both a value and a key.
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value_out == '0) || (out_key_out == '0))
    else $error("result carries both a value and a key");

  // A get right behind an insert of the same key sees the inserted value.
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(acc, 3) && ($past(in_opcode, 3) == lrukv_pkg::OP_INSERT)
     && $past(acc, 2) && ($past(in_opcode, 2) == lrukv_pkg::OP_GET)
     && ($past(in_key, 3) == $past(in_key, 2)))
    |-> (out_hit && (out_value_out == $past(in_value_in, 3))))
    else $error("get after insert missed the new value");

endmodule

bind lru_key_value_cache lrukv_checker u_lrukv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_opcode     (in_opcode),
  .in_key        (in_key),
  .in_value_in   (in_value_in),
  .out_valid     (out_valid),
  .out_hit       (out_hit),
  .out_value_out (out_value_out),
  .out_key_out   (out_key_out)
);
